FILE: design/indexed_list_engine_core_assert.svh
// Assertion macros shared by the checker
`ifndef INDEXED_LIST_ENGINE_CORE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define ILE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ILE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ile_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ile_pkg;

    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int CODE_W   = 3;
    localparam int TGT_W    = 5;
    localparam int ST_W     = 2;
    localparam int CNT_O_W  = 5;

    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_PAD    = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [POS_W-1:0]  position;
        logic [CODE_W-1:0] action_code;
        logic [TGT_W-1:0]  target_count;
    } cmd_t;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [CNT_O_W-1:0] entry_count;
        logic [CODE_W-1:0]  read_code;
    } res_t;

endpackage

`default_nettype wire

FILE: design/ile_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module ile_mem
    import ile_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [CODE_W-1:0] wdata,
    input  wire logic [AW-1:0]     raddr,
    output logic      [CODE_W-1:0] rdata
);

    logic [CODE_W-1:0] mem [DEPTH];
    logic [CODE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: design/ile_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module ile_seq
    import ile_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int CNT_W    = 5,
    parameter int AW       = 4
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire cmd_t              cmd,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output res_t                   res,
    output logic                   mem_we,
    output logic      [AW-1:0]     mem_waddr,
    output logic      [CODE_W-1:0] mem_wdata,
    output logic      [AW-1:0]     mem_raddr,
    input  wire logic [CODE_W-1:0] mem_rdata
);

    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_SHIFT = 7'b0000100,
        S_DRAIN = 7'b0001000,
        S_FILL  = 7'b0010000,
        S_RDATA = 7'b0100000,
        S_EMIT  = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pend_reg, pend_next;
    cmd_t               cmd_reg, cmd_next;
    logic [CNT_W-1:0]   cur_reg, cur_next;
    logic [CMP_W-1:0]   lim_reg, lim_next;
    logic [CMP_W-1:0]   fill_end_reg, fill_end_next;
    logic [AW-1:0]      wdst_reg, wdst_next;
    logic [ST_W-1:0]    status_reg, status_next;
    logic [CODE_W-1:0]  rd_reg, rd_next;

    logic [CMP_W-1:0]   cnt_x, pos_x, tgt_x, cur_x, eff_tgt, step_x, cnt_inc;
    logic               step_down;

    assign cnt_x   = CMP_W'(count_reg);
    assign pos_x   = CMP_W'(cmd_reg.position);
    assign tgt_x   = CMP_W'(cmd_reg.target_count);
    assign cur_x   = CMP_W'(cur_reg);
    assign eff_tgt = (tgt_x > CAP_C) ? CAP_C : tgt_x;
    assign cnt_inc = cnt_x + CMP_W'(1);

    // the one cursor stepper: walks down for an insert shift, up otherwise
    assign step_down = (state_reg == S_SHIFT) && (cmd_reg.operation == OP_INSERT);
    assign step_x    = step_down ? (cur_x - CMP_W'(1)) : (cur_x + CMP_W'(1));

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        pend_next     = pend_reg;
        cmd_next      = cmd_reg;
        cur_next      = cur_reg;
        lim_next      = lim_reg;
        fill_end_next = fill_end_reg;
        wdst_next     = wdst_reg;
        status_next   = status_reg;
        rd_next       = rd_reg;
        mem_we        = 1'b0;
        mem_waddr     = wdst_reg;
        mem_wdata     = mem_rdata;
        mem_raddr     = cur_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                status_next = ST_OK;
                rd_next     = '0;
                pend_next   = 1'b0;
                mem_raddr   = AW'(pos_x);
                state_next  = S_EMIT;
                unique case (cmd_reg.operation)
                    OP_APPEND:
                    begin
                        if (cnt_x >= CAP_C)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            cur_next      = count_reg;
                            fill_end_next = cnt_inc;
                            state_next    = S_FILL;
                        end
                    end
                    OP_INSERT:
                    begin
                        if (cnt_x >= CAP_C)
                        begin
                            status_next = ST_FULL;
                        end
                        else if (pos_x > cnt_x)
                        begin
                            status_next = ST_RANGE;
                        end
                        else if (pos_x == cnt_x)
                        begin
                            cur_next      = CNT_W'(pos_x);
                            fill_end_next = cnt_inc;
                            state_next    = S_FILL;
                        end
                        else
                        begin
                            cur_next   = count_reg;
                            lim_next   = pos_x;
                            state_next = S_SHIFT;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (cnt_x == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else if (pos_x >= cnt_x)
                        begin
                            status_next = ST_RANGE;
                        end
                        else if (pos_x == cnt_x - CMP_W'(1))
                        begin
                            // last entry: nothing to move
                            count_next = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            cur_next   = CNT_W'(pos_x);
                            lim_next   = cnt_x - CMP_W'(1);
                            state_next = S_SHIFT;
                        end
                    end
                    OP_PAD:
                    begin
                        if (tgt_x > CAP_C)
                        begin
                            status_next = ST_FULL;
                        end
                        if (cnt_x < eff_tgt)
                        begin
                            cur_next      = count_reg;
                            fill_end_next = eff_tgt;
                            state_next    = S_FILL;
                        end
                    end
                    OP_READ:
                    begin
                        if (cnt_x == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else if (pos_x >= cnt_x)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            state_next = S_RDATA;
                        end
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end

            S_SHIFT:
            begin
                // read source now, write it to its destination next cycle
                mem_raddr = step_x[AW-1:0];
                mem_we    = pend_reg;
                wdst_next = cur_reg[AW-1:0];
                pend_next = 1'b1;
                cur_next  = CNT_W'(step_x);
                if (step_x == lim_reg)
                begin
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                mem_we = 1'b1;
                if (cmd_reg.operation == OP_INSERT)
                begin
                    cur_next      = CNT_W'(pos_x);
                    fill_end_next = cnt_inc;
                    state_next    = S_FILL;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_EMIT;
                end
            end

            S_FILL:
            begin
                mem_we     = 1'b1;
                mem_waddr  = cur_reg[AW-1:0];
                mem_wdata  = cmd_reg.action_code;
                count_next = CNT_W'(cnt_inc);
                cur_next   = CNT_W'(step_x);
                if (cnt_inc >= fill_end_reg)
                begin
                    state_next = S_EMIT;
                end
            end

            S_RDATA:
            begin
                rd_next    = mem_rdata;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        cur_reg      <= cur_next;
        lim_reg      <= lim_next;
        fill_end_reg <= fill_end_next;
        wdst_reg     <= wdst_next;
        status_reg   <= status_next;
        rd_reg       <= rd_next;
    end

    assign cmd_ready       = (state_reg == S_IDLE);
    assign res_valid       = (state_reg == S_EMIT);
    assign res.status      = status_reg;
    assign res.entry_count = CNT_O_W'(count_reg);
    assign res.read_code   = rd_reg;

endmodule

`default_nettype wire

FILE: design/indexed_list_engine_core.sv
// Ordered list of 3-bit action codes held in a single-port-write, registered-read
// memory of CAPACITY entries. Each command transfer (append, insert at position,
// delete at position, pad to count, read) gives one result transfer carrying a
// status, the entry count afterwards and, for a good read, the code read. The
// list is walked by one cursor, one entry per cycle. After a check, a failing or
// unused command or a delete of the last entry goes straight to its result; a read
// first reads the memory; an insert inside the list or another delete first
// shifts the later entries and drains the last move; an append, an insert and a
// pad write their new entries before the result. Input is taken only while
// no command is in progress; a finished result waits in an output register, so
// the next command can start while it is still unclaimed. Entry contents are not
// cleared at reset.
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_engine_core
    import ile_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // operation[2:0], position[7:3], action_code[10:8], target_count[15:11]
    input  wire logic [15:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status[1:0], entry_count[6:2], read_code[9:7], zero[15:10]
    output logic      [15:0] m_axis_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    cmd_t              cmd;
    res_t              res;
    logic              res_valid, res_ready;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [CODE_W-1:0] mem_wdata, mem_rdata;

    logic              out_valid_reg;
    res_t              out_reg;

    assign cmd.operation    = s_axis_tdata[2:0];
    assign cmd.position     = s_axis_tdata[7:3];
    assign cmd.action_code  = s_axis_tdata[10:8];
    assign cmd.target_count = s_axis_tdata[15:11];

    ile_seq #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W),
        .AW       (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_axis_tvalid),
        .cmd_ready (s_axis_tready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ile_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_reg.read_code, out_reg.entry_count, out_reg.status};

endmodule

`default_nettype wire

FILE: design/ile_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_list_engine_core_assert.svh"

module ile_checker #(
    parameter int CAPACITY = 16
)
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);

    // a waiting result must hold
    `ILE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // one command at a time: busy straight after a command transfer
    `ILE_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "command taken while busy")

    // a code is only returned by a good read
    `ILE_ASSERT_NOW(a_code_ok, m_axis_tvalid && (m_axis_tdata[1:0] != 2'd0), m_axis_tdata[9:7] == 3'd0, "code on failed result")

    `ILE_ASSERT_NOW(a_cnt_cap, m_axis_tvalid, (CAPACITY > 30) || (m_axis_tdata[15:10] == 6'd0 && 32'(m_axis_tdata[6:2]) <= CAPACITY), "count above capacity or padding set")

endmodule

bind indexed_list_engine_core ile_checker #(.CAPACITY(CAPACITY)) u_ile_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
